// ----- src/tws_pkg.sv -----
// Shared types and constants for the triangular window smoother.
// Used by tws_cell, tws_div and triangular_window_smoother_top; no dependencies.
package tws_pkg;

    // Width of the half-width register and of a cell weight (h+1 <= 8)
    localparam int H_W   = 3;
    localparam int W_W   = 4;
    // Received-sample counter, saturates at the window length (<= 15)
    localparam int CNT_W = 4;
    // Divisor (h+1)^2 <= 64
    localparam int DIV_W = 7;
    // Extra accumulator bits above the sample width for a weight sum of 64
    localparam int GROW_W = 7;

    localparam logic [H_W-1:0] HALF_RESET = 3'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_OUT
    } t_state;

endpackage

// ----- src/triangular_window_smoother_top.sv -----
// Triangular window smoother, top level: tap chain, divider and output sequencer.
// Depends on tws_pkg, tws_cell and tws_div.
//
// Usage:
//   Samples enter on the s_axis channel (tdata = sample, tlast = end of stream);
//   results leave on the m_axis channel (tdata = smoothed, tlast = last result).
//   i_cfg_we with i_cfg_wdata sets the half width h (window 2h+1); a write also
//   restarts the stream count. Write only while the block is idle.
//   Each output stream is as long as its input stream: the first h results are
//   zeros issued together with the first full window, and h zeros follow the
//   result for the sample marked last. A stream shorter than a window gives zeros.
//   Flow: one sample at a time. A sample that yields no result only advances the count.
//   A sample that closes a window is accepted, then the weighted sum ripples
//   down the tap chain (TAPS = 2*MAX_HALF+1), then passes through the
//   bit-serial divider, and then the results are issued in order.
//   Short-stream zeros are issued after acceptance.
//   A stall on m_axis holds the current result in the output register; the next
//   sample is taken as soon as the sequencer is back in idle, even if that last
//   result is still waiting. Reset clears the stream count, sets h to 2 and
//   zeroes the delay line.
module triangular_window_smoother_top #(
    parameter int MAX_HALF     = 7,
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // s_axis tdata: [SAMPLE_WIDTH-1:0] sample, upper bits pad
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       i_s_axis_tdata,
    input  logic                                    i_s_axis_tlast,
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    // m_axis tdata: [SAMPLE_WIDTH-1:0] smoothed, upper bits zero
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       o_m_axis_tdata,
    output logic                                    o_m_axis_tlast,
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    input  logic                                    i_cfg_we,
    input  logic [tws_pkg::H_W-1:0]                 i_cfg_wdata
);

    localparam int TAPS    = 2 * MAX_HALF + 1;
    localparam int ACC_W   = SAMPLE_WIDTH + tws_pkg::GROW_W;
    localparam int TDATA_W = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int SC_W    = $clog2(TAPS + 1);
    localparam int CNT_W   = tws_pkg::CNT_W;
    localparam int H_W     = tws_pkg::H_W;

    tws_pkg::t_state r_state, n_state;

    logic [H_W-1:0]          r_half;
    logic [CNT_W-1:0]        r_rcnt, n_rcnt;
    logic [SC_W-1:0]         r_scnt, n_scnt;
    logic [CNT_W-1:0]        r_pre, n_pre;
    logic                    r_vpend, n_vpend;
    logic [H_W-1:0]          r_post, n_post;
    logic                    r_fin, n_fin;
    logic [SAMPLE_WIDTH-1:0] r_result;

    logic                    r_m_valid, n_m_valid;
    logic [SAMPLE_WIDTH-1:0] r_m_data, n_m_data;
    logic                    r_m_last, n_m_last;

    logic [H_W-1:0]          w_h;
    logic [CNT_W-1:0]        w_len;
    logic [CNT_W:0]          w_cnt;
    logic                    w_full;
    logic                    w_accept;
    logic                    w_slot;
    logic [CNT_W:0]          w_remain;
    logic                    w_div_start;
    logic                    w_div_done;
    logic [SAMPLE_WIDTH-1:0] w_quot;
    logic [CNT_W-1:0]        w_hp1;
    logic [2*CNT_W-1:0]      w_sq;

    logic signed [SAMPLE_WIDTH-1:0] w_data [TAPS+1];
    logic signed [ACC_W-1:0]        w_acc  [TAPS+1];

    // Effective half width and window length
    assign w_h   = (int'(r_half) > MAX_HALF) ? H_W'(MAX_HALF) : r_half;
    assign w_len = {w_h, 1'b1};
    assign w_cnt = {1'b0, r_rcnt} + 1'b1;
    assign w_full = w_cnt >= {1'b0, w_len};
    assign w_hp1 = {1'b0, w_h} + 1'b1;
    assign w_sq  = w_hp1 * w_hp1;

    assign o_s_axis_tready = (r_state == tws_pkg::ST_IDLE);
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_slot   = !r_m_valid || i_m_axis_tready;
    assign w_remain = {1'b0, r_pre} + {{CNT_W{1'b0}}, r_vpend} + {2'b00, r_post};
    assign w_div_start = (r_state == tws_pkg::ST_SUM) && (r_scnt == SC_W'(TAPS));

    // Tap chain
    assign w_data[0] = i_s_axis_tdata[SAMPLE_WIDTH-1:0];
    assign w_acc[0]  = '0;

    for (genvar k = 0; k < TAPS; k++) begin : g_tap
        tws_cell #(
            .K            (k),
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .ACC_W        (ACC_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_accept),
            .i_half  (w_h),
            .i_data  (w_data[k]),
            .i_acc   (w_acc[k]),
            .o_data  (w_data[k+1]),
            .o_acc   (w_acc[k+1])
        );
    end

    // Divide the window sum by (h+1)^2
    tws_div #(
        .ACC_W (ACC_W),
        .RES_W (SAMPLE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_acc[TAPS]),
        .i_divisor  (w_sq[tws_pkg::DIV_W-1:0]),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // Sequencer: next state, result plan and output register
    always_comb begin
        n_state   = r_state;
        n_rcnt    = r_rcnt;
        n_scnt    = r_scnt;
        n_pre     = r_pre;
        n_vpend   = r_vpend;
        n_post    = r_post;
        n_fin     = r_fin;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        n_m_last  = r_m_last;

        if (i_m_axis_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            tws_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_fin  = i_s_axis_tlast;
                    n_scnt = '0;
                    if (w_full) begin
                        n_pre   = (w_cnt == {1'b0, w_len}) ? {1'b0, w_h} : '0;
                        n_vpend = 1'b1;
                        n_post  = i_s_axis_tlast ? w_h : '0;
                        n_rcnt  = i_s_axis_tlast ? '0 : w_len;
                        n_state = tws_pkg::ST_SUM;
                    end else begin
                        n_pre   = i_s_axis_tlast ? w_cnt[CNT_W-1:0] : '0;
                        n_vpend = 1'b0;
                        n_post  = '0;
                        n_rcnt  = i_s_axis_tlast ? '0 : w_cnt[CNT_W-1:0];
                        n_state = i_s_axis_tlast ? tws_pkg::ST_OUT : tws_pkg::ST_IDLE;
                    end
                end
            end
            tws_pkg::ST_SUM: begin
                if (w_div_start) begin
                    n_state = tws_pkg::ST_DIV;
                end else begin
                    n_scnt = r_scnt + 1'b1;
                end
            end
            tws_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = tws_pkg::ST_OUT;
                end
            end
            tws_pkg::ST_OUT: begin
                if (w_slot) begin
                    n_m_valid = 1'b1;
                    n_m_last  = r_fin && (w_remain == (CNT_W+1)'(1));
                    if (r_pre != '0) begin
                        n_m_data = '0;
                        n_pre    = r_pre - 1'b1;
                    end else if (r_vpend) begin
                        n_m_data = r_result;
                        n_vpend  = 1'b0;
                    end else begin
                        n_m_data = '0;
                        n_post   = r_post - 1'b1;
                    end
                    if (w_remain == (CNT_W+1)'(1)) begin
                        n_state = tws_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = tws_pkg::ST_IDLE;
            end
        endcase

        // A register write restarts the stream
        if (i_cfg_we) begin
            n_rcnt = '0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tws_pkg::ST_IDLE;
            r_half    <= tws_pkg::HALF_RESET;
            r_rcnt    <= '0;
            r_scnt    <= '0;
            r_pre     <= '0;
            r_vpend   <= 1'b0;
            r_post    <= '0;
            r_fin     <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rcnt    <= n_rcnt;
            r_scnt    <= n_scnt;
            r_pre     <= n_pre;
            r_vpend   <= n_vpend;
            r_post    <= n_post;
            r_fin     <= n_fin;
            r_m_valid <= n_m_valid;
            if (i_cfg_we) begin
                r_half <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_m_data <= n_m_data;
        r_m_last <= n_m_last;
        if (w_div_done) begin
            r_result <= w_quot;
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = TDATA_W'(r_m_data);
    assign o_m_axis_tlast  = r_m_last;

    // Divider finishes only while the sequencer waits for it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == tws_pkg::ST_DIV))
        else $error("divider done outside divide state");

    // No sample is taken while results of the previous one are still pending
    a_plan_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> (r_pre == '0 && !r_vpend && r_post == '0))
        else $error("sample accepted with results pending");

    // In idle, the stream count never passes the window length
    a_rcnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tws_pkg::ST_IDLE) |-> (r_rcnt <= w_len))
        else $error("received count above window length");

    // The value slot is issued only after the divider has produced it
    a_value_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tws_pkg::ST_SUM && r_vpend) |=>
            (r_state == tws_pkg::ST_SUM || r_state == tws_pkg::ST_DIV))
        else $error("left sum phase without dividing");

endmodule

// ----- src/tws_cell.sv -----
// One tap of the smoother chain: holds a delay-line sample and adds its
// weighted value to the running sum passed along from the previous tap.
// Depends on tws_pkg.
module tws_cell #(
    parameter int K            = 0,
    parameter int SAMPLE_WIDTH = 16,
    parameter int ACC_W        = 23
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_shift,
    input  logic [tws_pkg::H_W-1:0]        i_half,
    input  logic signed [SAMPLE_WIDTH-1:0] i_data,
    input  logic signed [ACC_W-1:0]        i_acc,
    output logic signed [SAMPLE_WIDTH-1:0] o_data,
    output logic signed [ACC_W-1:0]        o_acc
);

    logic signed [SAMPLE_WIDTH-1:0] r_data;
    logic signed [ACC_W-1:0]        r_acc;
    logic [tws_pkg::W_W-1:0]        w_weight;

    // Triangular weight of this tap for the current half width
    always_comb begin
        int len_i;
        len_i = 2 * int'(i_half) + 1;
        if (K < len_i) begin
            w_weight = (K + 1 < len_i - K) ? tws_pkg::W_W'(K + 1) : tws_pkg::W_W'(len_i - K);
        end else begin
            w_weight = '0;
        end
    end

    // Shift the sample in on a new transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else if (i_shift) begin
            r_data <= i_data;
        end
    end

    // Advance the partial sum one tap per cycle; widen before the multiply
    always_ff @(posedge i_clk) begin
        r_acc <= i_acc + (ACC_W'(r_data) * ACC_W'($signed({1'b0, w_weight})));
    end

    assign o_data = r_data;
    assign o_acc  = r_acc;

endmodule

// ----- src/tws_div.sv -----
// Iterative signed divider: one quotient bit per cycle, truncating toward zero.
// Divides the window sum by (h+1)^2. Depends on tws_pkg.
module tws_div #(
    parameter int ACC_W = 23,
    parameter int RES_W = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [ACC_W-1:0]       i_dividend,
    input  logic [tws_pkg::DIV_W-1:0]     i_divisor,
    output logic                          o_done,
    output logic [RES_W-1:0]              o_quot
);

    localparam int CW = $clog2(ACC_W + 1);

    logic                        r_busy;
    logic                        r_done;
    logic [CW-1:0]               r_cnt;
    logic                        r_neg;
    logic [ACC_W-1:0]            r_mag;
    logic [tws_pkg::DIV_W-1:0]   r_rem;
    logic [tws_pkg::DIV_W-1:0]   r_dsr;
    logic [tws_pkg::DIV_W:0]     w_trial;
    logic [tws_pkg::DIV_W:0]     w_diff;
    logic                        w_ge;

    // Trial subtract of the next dividend bit
    always_comb begin
        w_trial = {r_rem, r_mag[ACC_W-1]};
        w_ge    = w_trial >= {1'b0, r_dsr};
        w_diff  = w_ge ? (w_trial - {1'b0, r_dsr}) : w_trial;
    end

    // Control: load on start, count down the quotient bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(ACC_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath: magnitude shifts out at the top, quotient bits enter at the bottom
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[ACC_W-1];
            r_mag <= i_dividend[ACC_W-1] ? ACC_W'(-i_dividend) : ACC_W'(i_dividend);
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_mag <= {r_mag[ACC_W-2:0], w_ge};
            r_rem <= w_diff[tws_pkg::DIV_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? (-r_mag[RES_W-1:0]) : r_mag[RES_W-1:0];

endmodule
